### src/ovl_pkg.sv
// Shared types and constants for the ordered value list unit.
package ovl_pkg;

  // Field widths fixed by the request and result formats.
  localparam int VALUE_W    = 32;
  localparam int MODE_W     = 2;
  localparam int POSITION_W = 6;
  localparam int COUNT_W    = 7;

  // Default list depth.
  localparam int CAPACITY_DEF = 64;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SORTED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd3;

  // One request transaction.
  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  // One result transaction.
  typedef struct packed {
    logic                  found;
    logic [POSITION_W-1:0] position;
    logic [COUNT_W-1:0]    count;
    logic                  dropped;
  } res_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                      cmp_en;
    logic                      ins_en;
    logic                      rem_en;
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

### src/ovl_cell.sv
// One list cell: holds one entry, compares it with the request and shifts with its neighbours.
module ovl_cell #(
  parameter int CAPACITY = ovl_pkg::CAPACITY_DEF,
  parameter int INDEX    = 0,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ovl_pkg::cell_ctrl_t                ctrl,
  input  logic [CW-1:0]                      count,
  input  logic                               sel,
  input  logic                               ge,
  input  logic signed [ovl_pkg::VALUE_W-1:0] prev_val,
  input  logic signed [ovl_pkg::VALUE_W-1:0] next_val,
  output logic signed [ovl_pkg::VALUE_W-1:0] val,
  output logic                               hit
);

  logic signed [ovl_pkg::VALUE_W-1:0] val_r;
  logic signed [ovl_pkg::VALUE_W-1:0] val_nxt;
  logic                               hit_r;
  logic                               hit_nxt;
  logic                               occupied;
  logic                               less;

  assign occupied = (count > CW'(INDEX));
  assign less     = (val_r < ctrl.value);

  // Match flag for the current request; the first cell that raises it is the target.
  always_comb begin
    case (ctrl.mode)
      ovl_pkg::MODE_APPEND: begin
        hit_nxt = !occupied;
      end
      ovl_pkg::MODE_SORTED: begin
        hit_nxt = !occupied || !less;
      end
      ovl_pkg::MODE_REMOVE, ovl_pkg::MODE_SEARCH: begin
        hit_nxt = occupied && (val_r == ctrl.value);
      end
      default: begin
        hit_nxt = 1'b0;
      end
    endcase
  end

  // Insertion takes the new value at the target and the left neighbour's value beyond it;
  // removal takes the right neighbour's value from the target onwards.
  always_comb begin
    val_nxt = val_r;
    if (ctrl.ins_en) begin
      if (sel) begin
        val_nxt = ctrl.value;
      end else if (ge) begin
        val_nxt = prev_val;
      end
    end else if (ctrl.rem_en && ge) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctrl.cmp_en) begin
      hit_r <= hit_nxt;
    end
  end

  assign val = val_r;
  assign hit = hit_r;

endmodule

### src/ordered_value_list_unit.sv
// Ordered value list: a row of cells sequenced through compare, select and update steps.
// The result is registered in the shift step, after the compare and first-hit select steps.
// A request is accepted only in idle, so the next one waits until this one has passed compare,
// first-hit select and shift; a result still stalled at the output holds the shift step until it is taken.
// Reset (rst_n low, synchronous) empties the list and clears the sequencer and output valid.
// No clearing pass is needed: entries beyond the count are never read.
module ordered_value_list_unit #(
  parameter int CAPACITY = ovl_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ovl_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ovl_pkg::res_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = $clog2(CAPACITY);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_SEL  = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0]          state_r;
  logic [1:0]          state_nxt;
  ovl_pkg::req_t       req_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic [CAPACITY-1:0] onehot_r;
  logic [CAPACITY-1:0] ge_r;
  logic                any_r;
  logic                out_valid_r;
  ovl_pkg::res_t       out_data_r;
  ovl_pkg::res_t       out_data_nxt;

  logic [CAPACITY-1:0] hit;
  logic [CAPACITY-1:0] hit_dec;
  logic signed [ovl_pkg::VALUE_W-1:0] cell_val [CAPACITY];
  ovl_pkg::cell_ctrl_t ctrl;
  logic                accept;
  logic                finish;
  logic                full;
  logic                is_insert;
  logic                ins_ok;
  logic                rem_ok;
  logic [PW-1:0]       pos_enc;
  logic [PW+ovl_pkg::POSITION_W-1:0] pos_ext;
  logic [CW+ovl_pkg::COUNT_W-1:0]    count_ext;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign finish    = (state_r == ST_UPD) && !(out_valid_r && out_stall);
  assign full      = (count_r == CW'(CAPACITY));
  assign is_insert = (req_r.mode == ovl_pkg::MODE_APPEND) ||
                     (req_r.mode == ovl_pkg::MODE_SORTED);
  assign ins_ok    = is_insert && !full;
  assign rem_ok    = (req_r.mode == ovl_pkg::MODE_REMOVE) && any_r;

  // Broadcast control to the cell row.
  always_comb begin
    ctrl.cmp_en = (state_r == ST_CMP);
    ctrl.ins_en = finish && ins_ok;
    ctrl.rem_en = finish && rem_ok;
    ctrl.mode   = req_r.mode;
    ctrl.value  = req_r.value;
  end

  // The row of cells, each wired to its neighbours; an end cell takes its own value in place of the missing one.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [ovl_pkg::VALUE_W-1:0] prev_val;
    logic signed [ovl_pkg::VALUE_W-1:0] next_val;

    if (g == 0) begin : g_first
      assign prev_val = cell_val[g];
    end else begin : g_mid_prev
      assign prev_val = cell_val[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign next_val = cell_val[g];
    end else begin : g_mid_next
      assign next_val = cell_val[g+1];
    end

    ovl_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .count    (count_r),
      .sel      (onehot_r[g]),
      .ge       (ge_r[g]),
      .prev_val (prev_val),
      .next_val (next_val),
      .val      (cell_val[g]),
      .hit      (hit[g])
    );
  end

  // First-hit select: isolate the lowest set flag and mark every cell from it onwards.
  assign hit_dec = hit - CAPACITY'(1);

  always_ff @(posedge clk) begin
    if (state_r == ST_SEL) begin
      onehot_r <= hit & ~hit_dec;
      ge_r     <= ~(hit ^ hit_dec) | (hit & ~hit_dec);
      any_r    <= |hit;
    end
  end

  // Encode the selected cell's index.
  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (onehot_r[i]) begin
        pos_enc = pos_enc | PW'(i);
      end
    end
  end

  // Entry count after the request.
  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (rem_ok) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Result fields, with position and count reduced to their field widths.
  always_comb begin
    pos_ext   = {{ovl_pkg::POSITION_W{1'b0}}, pos_enc};
    count_ext = {{ovl_pkg::COUNT_W{1'b0}}, count_nxt};
    out_data_nxt.found    = !is_insert && any_r;
    out_data_nxt.dropped  = is_insert && full;
    out_data_nxt.count    = count_ext[ovl_pkg::COUNT_W-1:0];
    if (ins_ok || (!is_insert && any_r)) begin
      out_data_nxt.position = pos_ext[ovl_pkg::POSITION_W-1:0];
    end else begin
      out_data_nxt.position = '0;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        state_nxt = ST_SEL;
      end
      ST_SEL: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    if (finish) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/ovl_checker.sv
// Port-level checks for the ordered value list unit, bound to its top level.
module ovl_checker #(
  parameter int CAPACITY = ovl_pkg::CAPACITY_DEF
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input ovl_pkg::req_t in_data,
  input logic          out_valid,
  input logic          out_stall,
  input ovl_pkg::res_t out_data
);

  // A refused insert means the list was full, so the count equals the capacity.
  a_drop_full : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.dropped) |-> (out_data.count == ovl_pkg::COUNT_W'(CAPACITY)))
    else $error("dropped insert reported with a list that is not full");

  // A result is never both a refused insert and a match.
  a_drop_found : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.dropped && out_data.found))
    else $error("result flags both dropped and found");

  // A stalled result holds until it is taken.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or vanished");

  // A stalled request transaction stays offered and unchanged.
  a_in_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_data)))
    else $error("stalled request changed or vanished");

  // No result appears in the cycle after reset.
  a_reset_quiet : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind ordered_value_list_unit ovl_checker #(.CAPACITY(CAPACITY)) u_ovl_checker (.*);
